// ===== sv/dual_motor_p_position_control_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor position control unit
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_P_POSITION_CONTROL_UNIT_DEFINES_SVH
`define DUAL_MOTOR_P_POSITION_CONTROL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DMPC_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("dmpc assertion failed");
`define DMPC_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("dmpc assertion failed");
`else
`define DMPC_ASSERT_IMP(lbl, c, r, ante, cons)
`define DMPC_ASSERT_NXT(lbl, c, r, ante, cons)
`endif

`endif

// ===== sv/dmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpc_pkg
// Shared types and constants of the dual motor position control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpc_pkg;

  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int ACTION_WIDTH    = 2;
  localparam int GAIN_WIDTH      = 8;
  localparam int HOLD_WIDTH      = 16;
  localparam int TARGET_WIDTH    = 16;

  localparam int RESET_GAIN      = 1;
  localparam int RESET_CURRENT   = 1023;
  localparam int RESET_HOLD      = 100;
  localparam int RESET_DUTY_MAX  = 255;

  typedef logic [ACTION_WIDTH-1:0]    action_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [GAIN_WIDTH-1:0]      gain_t;
  typedef logic [HOLD_WIDTH-1:0]      hold_t;

  localparam action_t ACT_CONTROL = 2'd0;
  localparam action_t ACT_ENC_ONE = 2'd1;
  localparam action_t ACT_ENC_TWO = 2'd2;

  localparam cfg_index_t REG_GAIN_ONE      = 3'd0;
  localparam cfg_index_t REG_GAIN_TWO      = 3'd1;
  localparam cfg_index_t REG_CURRENT_LIMIT = 3'd2;
  localparam cfg_index_t REG_CURRENT_CUT   = 3'd3;
  localparam cfg_index_t REG_HOLD_TIME     = 3'd4;
  localparam cfg_index_t REG_DUTY_MAX_ONE  = 3'd5;
  localparam cfg_index_t REG_DUTY_MAX_TWO  = 3'd6;
  localparam cfg_index_t REG_SYNC_MODE     = 3'd7;

  typedef struct packed {
    logic reduce;
    logic cutoff;
  } trim_t;

endpackage

`default_nettype wire

// ===== sv/dmpc_in_if.sv =====
// ----------------------------------------------------------------------------
// dmpc_in_if
// Input item channel: valid/ready handshake with encoder and control payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpc_in_if #(
  parameter int ADC_WIDTH = 10
);
  logic                                     valid;
  logic                                     ready;
  dmpc_pkg::action_t                        action;
  logic                                     enc_a;
  logic                                     enc_b;
  logic [ADC_WIDTH-1:0]                     current_ch0;
  logic [ADC_WIDTH-1:0]                     current_ch1;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] target_one;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] target_two;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] target_common;

  modport source (
    output valid, action, enc_a, enc_b, current_ch0, current_ch1,
           target_one, target_two, target_common,
    input  ready
  );

  modport sink (
    input  valid, action, enc_a, enc_b, current_ch0, current_ch1,
           target_one, target_two, target_common,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/dmpc_out_if.sv =====
// ----------------------------------------------------------------------------
// dmpc_out_if
// Result channel: valid/ready handshake with drive and position payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpc_out_if #(
  parameter int POS_WIDTH  = 16,
  parameter int DUTY_WIDTH = 8
);
  logic                        valid;
  logic                        ready;
  logic [DUTY_WIDTH-1:0]       duty_one;
  logic                        dir_one;
  logic [DUTY_WIDTH-1:0]       duty_two;
  logic                        dir_two;
  logic signed [POS_WIDTH-1:0] position_one;
  logic signed [POS_WIDTH-1:0] position_two;

  modport source (
    output valid, duty_one, dir_one, duty_two, dir_two, position_one, position_two,
    input  ready
  );

  modport sink (
    input  valid, duty_one, dir_one, duty_two, dir_two, position_one, position_two,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/dual_motor_p_position_control_unit.sv =====
// ----------------------------------------------------------------------------
// dual_motor_p_position_control_unit
// Two-motor proportional position controller with encoder counters and
// cross-coupled over-current duty reduction.
// ----------------------------------------------------------------------------
// Every input item gives one result. An item is taken into an input register,
// worked through one pass of logic (one gain multiply per motor, trim and
// clamp) and moves on to the result register when that is empty or being
// drained; the unit takes a new item every clock as long as results are
// drained, but a waiting result that is not taken blocks the next item from
// entering a full input register. Encoder items step the position counters;
// control items set duty and direction, which the following non-control
// items repeat. Configuration writes take effect on the next clock.
`default_nettype none
`include "dual_motor_p_position_control_unit_defines.svh"

module dual_motor_p_position_control_unit #(
  parameter int POS_WIDTH  = 16,
  parameter int DUTY_WIDTH = 8,
  parameter int ADC_WIDTH  = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire dmpc_pkg::cfg_index_t                 cfg_index,
  input  wire logic [dmpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  dmpc_in_if.sink                                   in_ch,
  dmpc_out_if.source                                out_ch
);

  localparam int REF_WIDTH = (POS_WIDTH > dmpc_pkg::TARGET_WIDTH) ? POS_WIDTH :
                             dmpc_pkg::TARGET_WIDTH;

  dmpc_pkg::gain_t        gain_one;
  dmpc_pkg::gain_t        gain_two;
  logic [ADC_WIDTH-1:0]   current_limit;
  logic [ADC_WIDTH-1:0]   current_cutoff;
  dmpc_pkg::hold_t        hold_time;
  logic [DUTY_WIDTH-1:0]  duty_max_one;
  logic [DUTY_WIDTH-1:0]  duty_max_two;
  logic                   sync_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_one       <= dmpc_pkg::GAIN_WIDTH'(dmpc_pkg::RESET_GAIN);
      gain_two       <= dmpc_pkg::GAIN_WIDTH'(dmpc_pkg::RESET_GAIN);
      current_limit  <= ADC_WIDTH'(dmpc_pkg::RESET_CURRENT);
      current_cutoff <= ADC_WIDTH'(dmpc_pkg::RESET_CURRENT);
      hold_time      <= dmpc_pkg::HOLD_WIDTH'(dmpc_pkg::RESET_HOLD);
      duty_max_one   <= DUTY_WIDTH'(dmpc_pkg::RESET_DUTY_MAX);
      duty_max_two   <= DUTY_WIDTH'(dmpc_pkg::RESET_DUTY_MAX);
      sync_mode      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dmpc_pkg::REG_GAIN_ONE:      gain_one       <= cfg_data[dmpc_pkg::GAIN_WIDTH-1:0];
        dmpc_pkg::REG_GAIN_TWO:      gain_two       <= cfg_data[dmpc_pkg::GAIN_WIDTH-1:0];
        dmpc_pkg::REG_CURRENT_LIMIT: current_limit  <= cfg_data[ADC_WIDTH-1:0];
        dmpc_pkg::REG_CURRENT_CUT:   current_cutoff <= cfg_data[ADC_WIDTH-1:0];
        dmpc_pkg::REG_HOLD_TIME:     hold_time      <= cfg_data[dmpc_pkg::HOLD_WIDTH-1:0];
        dmpc_pkg::REG_DUTY_MAX_ONE:  duty_max_one   <= cfg_data[DUTY_WIDTH-1:0];
        dmpc_pkg::REG_DUTY_MAX_TWO:  duty_max_two   <= cfg_data[DUTY_WIDTH-1:0];
        dmpc_pkg::REG_SYNC_MODE:     sync_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  logic                                     s1_valid;
  dmpc_pkg::action_t                        s1_action;
  logic                                     s1_enc_a;
  logic                                     s1_enc_b;
  logic [ADC_WIDTH-1:0]                     s1_current_ch0;
  logic [ADC_WIDTH-1:0]                     s1_current_ch1;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] s1_target_one;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] s1_target_two;
  logic signed [dmpc_pkg::TARGET_WIDTH-1:0] s1_target_common;

  logic res_valid;
  logic advance;
  logic ctl_step;

  assign advance     = s1_valid && (!res_valid || out_ch.ready);
  assign ctl_step    = advance && (s1_action == dmpc_pkg::ACT_CONTROL);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action        <= in_ch.action;
      s1_enc_a         <= in_ch.enc_a;
      s1_enc_b         <= in_ch.enc_b;
      s1_current_ch0   <= in_ch.current_ch0;
      s1_current_ch1   <= in_ch.current_ch1;
      s1_target_one    <= in_ch.target_one;
      s1_target_two    <= in_ch.target_two;
      s1_target_common <= in_ch.target_common;
    end
  end

  logic [POS_WIDTH-1:0] pos_one;
  logic [POS_WIDTH-1:0] pos_one_next;
  logic [POS_WIDTH-1:0] pos_two;
  logic [POS_WIDTH-1:0] pos_two_next;

  dmpc_enc_count #(.POS_WIDTH(POS_WIDTH)) u_enc_one (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && (s1_action == dmpc_pkg::ACT_ENC_ONE) && s1_enc_a),
    .up       (!s1_enc_b),
    .pos      (pos_one),
    .pos_next (pos_one_next)
  );

  dmpc_enc_count #(.POS_WIDTH(POS_WIDTH)) u_enc_two (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && (s1_action == dmpc_pkg::ACT_ENC_TWO) && s1_enc_a),
    .up       (s1_enc_b),
    .pos      (pos_two),
    .pos_next (pos_two_next)
  );

  dmpc_pkg::trim_t trim_one;
  dmpc_pkg::trim_t trim_two;

  dmpc_hold_timer #(.ADC_WIDTH(ADC_WIDTH)) u_hold_one (
    .clk       (clk),
    .rst       (rst),
    .step      (ctl_step),
    .current   (s1_current_ch0),
    .limit     (current_limit),
    .hold_time (hold_time),
    .reduce    (trim_two.reduce)
  );

  dmpc_hold_timer #(.ADC_WIDTH(ADC_WIDTH)) u_hold_two (
    .clk       (clk),
    .rst       (rst),
    .step      (ctl_step),
    .current   (s1_current_ch1),
    .limit     (current_limit),
    .hold_time (hold_time),
    .reduce    (trim_one.reduce)
  );

  assign trim_one.cutoff = s1_current_ch1 >= current_cutoff;
  assign trim_two.cutoff = s1_current_ch0 >= current_cutoff;

  logic signed [REF_WIDTH-1:0] ref_one;
  logic signed [REF_WIDTH-1:0] ref_two;

  assign ref_one = sync_mode ? REF_WIDTH'(s1_target_common) : REF_WIDTH'(s1_target_one);
  assign ref_two = sync_mode ? REF_WIDTH'($signed(pos_one)) : REF_WIDTH'(s1_target_two);

  logic [DUTY_WIDTH-1:0] duty_one_next;
  logic [DUTY_WIDTH-1:0] duty_two_next;
  logic                  neg_one;
  logic                  neg_two;

  dmpc_axis_drive #(.POS_WIDTH(POS_WIDTH), .DUTY_WIDTH(DUTY_WIDTH)) u_drive_one (
    .target   (ref_one),
    .position ($signed(pos_one)),
    .gain     (gain_one),
    .trim     (trim_one),
    .duty_max (duty_max_one),
    .duty     (duty_one_next),
    .negative (neg_one)
  );

  dmpc_axis_drive #(.POS_WIDTH(POS_WIDTH), .DUTY_WIDTH(DUTY_WIDTH)) u_drive_two (
    .target   (ref_two),
    .position ($signed(pos_two)),
    .gain     (gain_two),
    .trim     (trim_two),
    .duty_max (duty_max_two),
    .duty     (duty_two_next),
    .negative (neg_two)
  );

  logic [DUTY_WIDTH-1:0] res_duty_one;
  logic [DUTY_WIDTH-1:0] res_duty_two;
  logic                  res_dir_one;
  logic                  res_dir_two;
  logic [POS_WIDTH-1:0]  res_pos_one;
  logic [POS_WIDTH-1:0]  res_pos_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // hold the applied drive across non-control items
  always_ff @(posedge clk) begin
    if (rst) begin
      res_duty_one <= '0;
      res_duty_two <= '0;
      res_dir_one  <= 1'b0;
      res_dir_two  <= 1'b0;
    end else if (ctl_step) begin
      res_duty_one <= duty_one_next;
      res_duty_two <= duty_two_next;
      res_dir_one  <= neg_one;
      res_dir_two  <= !neg_two;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_pos_one <= pos_one_next;
      res_pos_two <= pos_two_next;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.duty_one     = res_duty_one;
  assign out_ch.dir_one      = res_dir_one;
  assign out_ch.duty_two     = res_duty_two;
  assign out_ch.dir_two      = res_dir_two;
  assign out_ch.position_one = $signed(res_pos_one);
  assign out_ch.position_two = $signed(res_pos_two);

  `DMPC_ASSERT_NXT(a_drive_held, clk, rst, advance && (s1_action != dmpc_pkg::ACT_CONTROL), $stable(res_duty_one) && $stable(res_duty_two))
  `DMPC_ASSERT_NXT(a_cutoff_two, clk, rst, ctl_step && (s1_current_ch0 >= current_cutoff), res_duty_two == '0)
  `DMPC_ASSERT_NXT(a_clamp_one, clk, rst, ctl_step, res_duty_one <= $past(duty_max_one))
  `DMPC_ASSERT_IMP(a_ready_free, clk, rst, !res_valid, in_ch.ready)

endmodule

`default_nettype wire

// ===== sv/dmpc_enc_count.sv =====
// ----------------------------------------------------------------------------
// dmpc_enc_count
// Wrapping up/down position counter stepped by encoder edges.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpc_enc_count #(
  parameter int POS_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 up,
  output logic [POS_WIDTH-1:0]      pos,
  output logic [POS_WIDTH-1:0]      pos_next
);

  always_comb begin
    pos_next = pos;
    if (step) begin
      pos_next = up ? pos + POS_WIDTH'(1) : pos - POS_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dmpc_hold_timer.sv =====
// ----------------------------------------------------------------------------
// dmpc_hold_timer
// Over-current hold timer; flags duty reduction once the hold time has run.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpc_hold_timer #(
  parameter int ADC_WIDTH = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [ADC_WIDTH-1:0] current,
  input  wire logic [ADC_WIDTH-1:0] limit,
  input  wire dmpc_pkg::hold_t      hold_time,
  output logic                      reduce
);

  dmpc_pkg::hold_t count;
  dmpc_pkg::hold_t count_next;
  logic            over;
  logic            expired;

  assign over    = current >= limit;
  assign expired = count >= hold_time;
  assign reduce  = over && expired;

  always_comb begin
    count_next = count;
    if (step) begin
      if (over) begin
        if (!expired) begin
          count_next = count + dmpc_pkg::HOLD_WIDTH'(1);
        end
      end else if (expired) begin
        count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dmpc_axis_drive.sv =====
// ----------------------------------------------------------------------------
// dmpc_axis_drive
// Proportional command for one motor: error times gain, magnitude and sign,
// current trim and duty clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpc_axis_drive #(
  parameter int POS_WIDTH  = 16,
  parameter int DUTY_WIDTH = 8
) (
  input  wire logic signed [((POS_WIDTH > dmpc_pkg::TARGET_WIDTH) ? POS_WIDTH :
                             dmpc_pkg::TARGET_WIDTH)-1:0] target,
  input  wire logic signed [POS_WIDTH-1:0]               position,
  input  wire dmpc_pkg::gain_t                           gain,
  input  wire dmpc_pkg::trim_t                           trim,
  input  wire logic [DUTY_WIDTH-1:0]                     duty_max,
  output logic [DUTY_WIDTH-1:0]                          duty,
  output logic                                           negative
);

  localparam int REF_WIDTH = (POS_WIDTH > dmpc_pkg::TARGET_WIDTH) ? POS_WIDTH :
                             dmpc_pkg::TARGET_WIDTH;
  localparam int ERR_WIDTH = REF_WIDTH + 1;
  localparam int PRD_WIDTH = ERR_WIDTH + dmpc_pkg::GAIN_WIDTH + 1;

  logic signed [ERR_WIDTH-1:0] err;
  logic signed [PRD_WIDTH-1:0] prod;
  logic [PRD_WIDTH-1:0]        mag;
  logic [PRD_WIDTH-1:0]        mag_trim;

  assign err      = ERR_WIDTH'(target) - ERR_WIDTH'(position);
  assign prod     = PRD_WIDTH'(err) * PRD_WIDTH'($signed({1'b0, gain}));
  assign negative = prod[PRD_WIDTH-1];
  assign mag      = negative ? PRD_WIDTH'(-prod) : PRD_WIDTH'(prod);

  always_comb begin
    mag_trim = mag;
    if (trim.reduce && (mag != '0)) begin
      mag_trim = mag - PRD_WIDTH'(1);
    end
    if (trim.cutoff) begin
      mag_trim = '0;
    end
  end

  assign duty = (mag_trim <= PRD_WIDTH'(duty_max)) ? DUTY_WIDTH'(mag_trim) : duty_max;

endmodule

`default_nettype wire

// ===== tb/dual_motor_p_position_control_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_motor_p_position_control_unit_tb
// Feeds encoder edges and control steps into the position controller with
// random source gaps and sink stalls. An in-bench controller model tracks the
// counters, hold timers and applied drive, and every result transfer is
// checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module dual_motor_p_position_control_unit_tb;

  localparam int POS_W         = 16;
  localparam int DUTY_W        = 8;
  localparam int ADC_W         = 10;
  localparam int ADC_MAX       = (1 << ADC_W) - 1;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 100;
  localparam int RUN_LIMIT_NS  = 20_000_000;
  localparam dmpc_pkg::action_t ACT_UNUSED = 2'd3;

  typedef logic [ADC_W-1:0]                         adc_t;
  typedef logic [DUTY_W-1:0]                        duty_t;
  typedef logic signed [POS_W-1:0]                  pos_t;
  typedef logic signed [dmpc_pkg::TARGET_WIDTH-1:0] target_t;

  typedef struct packed {
    dmpc_pkg::action_t action;
    logic              enc_a;
    logic              enc_b;
    adc_t              current_ch0;
    adc_t              current_ch1;
    target_t           target_one;
    target_t           target_two;
    target_t           target_common;
  } cmd_t;

  typedef struct packed {
    duty_t duty_one;
    logic  dir_one;
    duty_t duty_two;
    logic  dir_two;
    pos_t  position_one;
    pos_t  position_two;
  } drive_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_wr_en;
  dmpc_pkg::cfg_index_t                cfg_index;
  logic [dmpc_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

  dmpc_in_if  #(.ADC_WIDTH(ADC_W))                        in_ch ();
  dmpc_out_if #(.POS_WIDTH(POS_W), .DUTY_WIDTH(DUTY_W))   out_ch ();

  dual_motor_p_position_control_unit #(
    .POS_WIDTH  (POS_W),
    .DUTY_WIDTH (DUTY_W),
    .ADC_WIDTH  (ADC_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // controller model: settings and state
  dmpc_pkg::gain_t gain_m1, gain_m2;
  adc_t            cur_limit, cur_cutoff;
  dmpc_pkg::hold_t hold_time_r;
  duty_t           duty_cap [2];
  logic            sync_on;
  pos_t            pos_m [2];
  dmpc_pkg::hold_t hold_cnt [2];
  drive_t          held_drive;

  cmd_t   pending_cmds [$];
  drive_t expected_drives [$];
  int     gen_pos [2];
  int     in_flight;
  int     errors;
  int     in_gap;
  int     out_stall;
  bit     in_taken;
  bit     idle_on;
  cmd_t   next_cmd;
  cmd_t   seen_cmd;
  drive_t want;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic hold_expired(int idx, adc_t cur);
    if (cur >= cur_limit) begin
      if (hold_cnt[idx] >= hold_time_r) return 1'b1;
      hold_cnt[idx] = hold_cnt[idx] + 1'b1;
    end else if (hold_cnt[idx] >= hold_time_r) begin
      hold_cnt[idx] = '0;
    end
    return 1'b0;
  endfunction

  function automatic drive_t step_controller(cmd_t c);
    int p1, p2, cmd1, cmd2, mag1, mag2;
    case (c.action)
      dmpc_pkg::ACT_ENC_ONE: begin
        if (c.enc_a) pos_m[0] = c.enc_b ? pos_m[0] - 1'b1 : pos_m[0] + 1'b1;
      end
      dmpc_pkg::ACT_ENC_TWO: begin
        if (c.enc_a) pos_m[1] = c.enc_b ? pos_m[1] + 1'b1 : pos_m[1] - 1'b1;
      end
      dmpc_pkg::ACT_CONTROL: begin
        p1 = int'(pos_m[0]);
        p2 = int'(pos_m[1]);
        if (sync_on) begin
          cmd1 = (int'(c.target_common) - p1) * int'(gain_m1);
          cmd2 = (p1 - p2) * int'(gain_m2);
        end else begin
          cmd1 = (int'(c.target_one) - p1) * int'(gain_m1);
          cmd2 = (int'(c.target_two) - p2) * int'(gain_m2);
        end
        held_drive.dir_one = (cmd1 < 0);
        held_drive.dir_two = !(cmd2 < 0);
        mag1 = (cmd1 < 0) ? -cmd1 : cmd1;
        mag2 = (cmd2 < 0) ? -cmd2 : cmd2;
        if (hold_expired(0, c.current_ch0) && mag2 > 0) mag2--;
        if (hold_expired(1, c.current_ch1) && mag1 > 0) mag1--;
        if (c.current_ch0 >= cur_cutoff) mag2 = 0;
        if (c.current_ch1 >= cur_cutoff) mag1 = 0;
        held_drive.duty_one = (mag1 <= int'(duty_cap[0])) ? duty_t'(mag1) : duty_cap[0];
        held_drive.duty_two = (mag2 <= int'(duty_cap[1])) ? duty_t'(mag2) : duty_cap[1];
      end
      default: ;
    endcase
    held_drive.position_one = pos_m[0];
    held_drive.position_two = pos_m[1];
    return held_drive;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_level(int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return hi;
    return $urandom_range(0, hi);
  endfunction

  function automatic adc_t pick_current();
    int r, v, off;
    r = $urandom_range(0, 99);
    if (r < 35) return adc_t'($urandom);
    if (r < 50) return adc_t'($urandom_range(0, int'(cur_limit)));
    off = $urandom_range(0, 6);
    v = ((r < 80) ? int'(cur_limit) : int'(cur_cutoff)) + off - 3;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return adc_t'(v);
  endfunction

  function automatic target_t pick_target(int pos);
    int off;
    if ($urandom_range(0, 1) == 0) return target_t'($urandom);
    off = $urandom_range(0, 600);
    return target_t'(pos + off - 300);
  endfunction

  function automatic cmd_t mk(dmpc_pkg::action_t act, int ea, int eb, int ch0, int ch1,
                              int t1, int t2, int tc);
    cmd_t c;
    c.action        = act;
    c.enc_a         = ea[0];
    c.enc_b         = eb[0];
    c.current_ch0   = adc_t'(ch0);
    c.current_ch1   = adc_t'(ch1);
    c.target_one    = target_t'(t1);
    c.target_two    = target_t'(t2);
    c.target_common = target_t'(tc);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.action        = (r < 40) ? dmpc_pkg::ACT_CONTROL :
                      (r < 68) ? dmpc_pkg::ACT_ENC_ONE :
                      (r < 96) ? dmpc_pkg::ACT_ENC_TWO : ACT_UNUSED;
    c.enc_a         = ($urandom_range(0, 9) != 0);
    c.enc_b         = 1'($urandom_range(0, 1));
    c.current_ch0   = pick_current();
    c.current_ch1   = pick_current();
    c.target_one    = pick_target(gen_pos[0]);
    c.target_two    = pick_target(gen_pos[1]);
    c.target_common = pick_target(gen_pos[0]);
    return c;
  endfunction

  task automatic add_cmd(cmd_t c);
    if (c.enc_a && c.action == dmpc_pkg::ACT_ENC_ONE) gen_pos[0] += c.enc_b ? -1 : 1;
    if (c.enc_a && c.action == dmpc_pkg::ACT_ENC_TWO) gen_pos[1] += c.enc_b ? 1 : -1;
    pending_cmds.push_back(c);
    in_flight++;
  endtask

  task automatic write_reg(dmpc_pkg::cfg_index_t idx, int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[dmpc_pkg::CFG_DATA_WIDTH-1:0];
    case (idx)
      dmpc_pkg::REG_GAIN_ONE:      gain_m1     = value[dmpc_pkg::GAIN_WIDTH-1:0];
      dmpc_pkg::REG_GAIN_TWO:      gain_m2     = value[dmpc_pkg::GAIN_WIDTH-1:0];
      dmpc_pkg::REG_CURRENT_LIMIT: cur_limit   = value[ADC_W-1:0];
      dmpc_pkg::REG_CURRENT_CUT:   cur_cutoff  = value[ADC_W-1:0];
      dmpc_pkg::REG_HOLD_TIME:     hold_time_r = value[dmpc_pkg::HOLD_WIDTH-1:0];
      dmpc_pkg::REG_DUTY_MAX_ONE:  duty_cap[0] = value[DUTY_W-1:0];
      dmpc_pkg::REG_DUTY_MAX_TWO:  duty_cap[1] = value[DUTY_W-1:0];
      dmpc_pkg::REG_SYNC_MODE:     sync_on     = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_config(int g1, int g2, int limit, int cutoff, int hold,
                              int cap1, int cap2, int sync);
    write_reg(dmpc_pkg::REG_GAIN_ONE, g1);
    write_reg(dmpc_pkg::REG_GAIN_TWO, g2);
    write_reg(dmpc_pkg::REG_CURRENT_LIMIT, limit);
    write_reg(dmpc_pkg::REG_CURRENT_CUT, cutoff);
    write_reg(dmpc_pkg::REG_HOLD_TIME, hold);
    write_reg(dmpc_pkg::REG_DUTY_MAX_ONE, cap1);
    write_reg(dmpc_pkg::REG_DUTY_MAX_TWO, cap2);
    write_reg(dmpc_pkg::REG_SYNC_MODE, sync);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (in_flight != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // input driver: hold the item until its transfer, then advance
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.action        <= next_cmd.action;
        in_ch.enc_a         <= next_cmd.enc_a;
        in_ch.enc_b         <= next_cmd.enc_b;
        in_ch.current_ch0   <= next_cmd.current_ch0;
        in_ch.current_ch1   <= next_cmd.current_ch1;
        in_ch.target_one    <= next_cmd.target_one;
        in_ch.target_two    <= next_cmd.target_two;
        in_ch.target_common <= next_cmd.target_common;
        if (idle_on && $urandom_range(0, 2) == 0) in_gap = gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) out_stall = gap_len();
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen_cmd.action        = in_ch.action;
      seen_cmd.enc_a         = in_ch.enc_a;
      seen_cmd.enc_b         = in_ch.enc_b;
      seen_cmd.current_ch0   = in_ch.current_ch0;
      seen_cmd.current_ch1   = in_ch.current_ch1;
      seen_cmd.target_one    = in_ch.target_one;
      seen_cmd.target_two    = in_ch.target_two;
      seen_cmd.target_common = in_ch.target_common;
      expected_drives.push_back(step_controller(seen_cmd));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_drives.size() == 0) begin
        $error("result transfer with no expected drive pending");
        errors++;
      end else begin
        want = expected_drives.pop_front();
        in_flight--;
        check_field("duty_one", want.duty_one, out_ch.duty_one);
        check_field("dir_one", want.dir_one, out_ch.dir_one);
        check_field("duty_two", want.duty_two, out_ch.duty_two);
        check_field("dir_two", want.dir_two, out_ch.dir_two);
        check_field("position_one", $signed(want.position_one), $signed(out_ch.position_one));
        check_field("position_two", $signed(want.position_two), $signed(out_ch.position_two));
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main
    cmd_t run_cmd;
    int   run_len;
    int   r;

    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = dmpc_pkg::REG_GAIN_ONE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = dmpc_pkg::ACT_CONTROL;
    in_ch.enc_a         = 1'b0;
    in_ch.enc_b         = 1'b0;
    in_ch.current_ch0   = '0;
    in_ch.current_ch1   = '0;
    in_ch.target_one    = '0;
    in_ch.target_two    = '0;
    in_ch.target_common = '0;
    out_ch.ready        = 1'b0;
    idle_on             = 1'b1;
    gain_m1             = dmpc_pkg::gain_t'(dmpc_pkg::RESET_GAIN);
    gain_m2             = dmpc_pkg::gain_t'(dmpc_pkg::RESET_GAIN);
    cur_limit           = adc_t'(dmpc_pkg::RESET_CURRENT);
    cur_cutoff          = adc_t'(dmpc_pkg::RESET_CURRENT);
    hold_time_r         = dmpc_pkg::hold_t'(dmpc_pkg::RESET_HOLD);
    duty_cap[0]         = duty_t'(dmpc_pkg::RESET_DUTY_MAX);
    duty_cap[1]         = duty_t'(dmpc_pkg::RESET_DUTY_MAX);
    sync_on             = 1'b0;
    pos_m[0]            = '0;
    pos_m[1]            = '0;
    hold_cnt[0]         = '0;
    hold_cnt[1]         = '0;
    held_drive          = '0;
    gen_pos[0]          = 0;
    gen_pos[1]          = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes, encoder directions, cutoff, undefined action
    add_cmd(mk(ACT_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 0, 0, 32767, -32768, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_ONE, 1, 1, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_ONE, 1, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_ONE, 1, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_ONE, 0, 1, ADC_MAX, ADC_MAX, -1, -1, -1));
    add_cmd(mk(dmpc_pkg::ACT_ENC_TWO, 1, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_TWO, 1, 1, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_ENC_TWO, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 0, 0, gen_pos[0], gen_pos[1], 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, ADC_MAX, ADC_MAX, -32768, 32767, 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, ADC_MAX - 1, ADC_MAX - 1, gen_pos[0] - 5,
               gen_pos[1] + 3, 0));
    add_cmd(mk(ACT_UNUSED, 1, 1, ADC_MAX, ADC_MAX, -1, -1, -1));
    drain();

    // hold timer expiry, reduction floored at zero, clearing, cutoff
    apply_config(1, 1, 500, 1000, 2, 255, 255, 0);
    repeat (3) add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 600, 600, gen_pos[0] + 1,
                          gen_pos[1], 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 400, 400, gen_pos[0] + 2, gen_pos[1] - 2, 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 1000, 1000, gen_pos[0] - 7, gen_pos[1] + 7, 0));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // motor two follows motor one
    apply_config(2, 3, ADC_MAX, ADC_MAX, 100, 10, 20, 1);
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 0, 0, 0, 0, gen_pos[0] + 100));
    add_cmd(mk(dmpc_pkg::ACT_CONTROL, 0, 0, 0, 0, 0, 0, gen_pos[0] - 3));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        apply_config(255, 255, ADC_MAX, ADC_MAX, 65535, 255, 255, 1);
      end else if (phase == 1) begin
        apply_config(0, 0, 0, 0, 0, 0, 0, 0);
      end else begin
        r = $urandom_range(0, 9);
        apply_config(pick_level(255), pick_level(255), pick_level(ADC_MAX),
                     pick_level(ADC_MAX),
                     (r == 0) ? 65535 : (r == 1) ? 0 : $urandom_range(1, 6),
                     pick_level(255), pick_level(255), $urandom_range(0, 1));
      end
      idle_on = (phase % 4 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          run_cmd        = random_cmd();
          run_cmd.action = $urandom_range(0, 1) ? dmpc_pkg::ACT_ENC_ONE :
                                                  dmpc_pkg::ACT_ENC_TWO;
          run_cmd.enc_a  = 1'b1;
          run_len        = $urandom_range(2, 30);
          repeat (run_len) add_cmd(run_cmd);
          run_cmd        = random_cmd();
          run_cmd.action = dmpc_pkg::ACT_CONTROL;
          add_cmd(run_cmd);
          n += run_len;
        end else begin
          add_cmd(random_cmd());
        end
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
